// ===== design/betweenness_centrality_engine_core_assert.svh =====
// assertion macros used by the core rtl file
`ifndef BETWEENNESS_CENTRALITY_ENGINE_CORE_ASSERT_SVH
`define BETWEENNESS_CENTRALITY_ENGINE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define BCE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bce_pkg.sv =====
`default_nettype none

package bce_pkg;

    // graph store sizes
    localparam int MAX_VERTICES     = 1024;
    localparam int VADDR_W          = $clog2(MAX_VERTICES);
    localparam int VCNT_W           = VADDR_W + 1;
    localparam int MAX_EDGE_ENTRIES = 4096;
    localparam int EADDR_W          = $clog2(MAX_EDGE_ENTRIES);
    localparam int EPTR_W           = EADDR_W + 1;

    // arithmetic widths
    localparam int PATH_W  = 40;
    localparam int FRAC_W  = 16;
    localparam int SCORE_W = 48;
    localparam int DIST_W  = 11;
    localparam int MB_W    = SCORE_W + 1;
    localparam int MUL_W   = PATH_W + MB_W;
    localparam int CNT_W   = $clog2(MUL_W);

    localparam logic [EPTR_W-1:0]  LIST_END  = EPTR_W'(MAX_EDGE_ENTRIES);
    localparam logic [DIST_W-1:0]  UNREACHED = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [PATH_W-1:0]  PATH_MAX  = '1;
    localparam logic [MB_W-1:0]    ONE_FIXED = MB_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ENDPOINT = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== design/bce_in_if.sv =====
`default_nettype none

interface bce_in_if;
    import bce_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [VADDR_W-1:0] vertex_a;
    logic [VADDR_W-1:0] vertex_b;

    modport source (output valid, op, vertex_a, vertex_b, input ready);
    modport sink   (input valid, op, vertex_a, vertex_b, output ready);
endinterface

`default_nettype wire

// ===== design/bce_out_if.sv =====
`default_nettype none

interface bce_out_if;
    import bce_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [SCORE_W-1:0] score;
    logic               saturated;

    modport source (output valid, status, score, saturated, input ready);
    modport sink   (input valid, status, score, saturated, output ready);
endinterface

`default_nettype wire

// ===== design/bce_cfg_if.sv =====
`default_nettype none

interface bce_cfg_if;
    import bce_pkg::*;

    logic              valid;
    logic              ready;
    logic [VCNT_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// ===== design/bce_ram.sv =====
`default_nettype none

module bce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== design/bce_muldiv.sv =====
`default_nettype none

module bce_muldiv (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bce_pkg::PATH_W-1:0]    i_a,
    input  wire logic [bce_pkg::MB_W-1:0]      i_b,
    input  wire logic [bce_pkg::PATH_W-1:0]    i_d,
    output logic                               o_done,
    output logic      [bce_pkg::SCORE_W-1:0]   o_q
);
    import bce_pkg::*;

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} t_md_state;

    t_md_state          r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [MUL_W-1:0]   r_acc;
    logic [MUL_W-1:0]   r_mcand;
    logic [MB_W-1:0]    r_mplier;
    logic [PATH_W-1:0]  r_d;
    logic [PATH_W-1:0]  r_rem;
    logic [SCORE_W-1:0] r_q;
    logic               r_over;
    logic               r_done;

    logic [PATH_W:0]    n_trial;
    logic [PATH_W:0]    n_diff;
    logic               n_qbit;

    // one restoring division step
    always_comb begin
        n_trial = {r_rem, r_acc[MUL_W-1]};
        n_diff  = n_trial - {1'b0, r_d};
        n_qbit  = (n_trial >= {1'b0, r_d});
    end

    // shift-add multiply, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == MD_DIV) && (r_cnt == '0);
            unique case (r_state)
                MD_IDLE: begin
                    if (i_start) begin
                        r_acc    <= '0;
                        r_mcand  <= MUL_W'(i_a);
                        r_mplier <= i_b;
                        r_d      <= i_d;
                        r_cnt    <= CNT_W'(MB_W - 1);
                        r_state  <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(MUL_W - 1);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_over  <= 1'b0;
                        r_state <= MD_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                MD_DIV: begin
                    r_acc <= r_acc << 1;
                    r_rem <= n_qbit ? n_diff[PATH_W-1:0] : n_trial[PATH_W-1:0];
                    r_q   <= {r_q[SCORE_W-2:0], n_qbit};
                    if (n_qbit && (r_cnt >= CNT_W'(SCORE_W))) begin
                        r_over <= 1'b1;
                    end
                    if (r_cnt == '0) begin
                        r_state <= MD_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_over ? SCORE_MAX : r_q;
endmodule

`default_nettype wire

// ===== design/betweenness_centrality_engine_core.sv =====
// channel   dir   word                                handshake
// i_in      in    op, vertex_a, vertex_b              valid / ready
// o_out     out   status, score, saturated            valid / ready
// i_cfg     in    vertex_count                        valid / ready (always ready)
//
// add edge writes both list entries; a rejected add or read goes straight to S_DONE; clear
// sweeps the lists. run: a sweep zeroes the scores, then per source an init of every
// vertex and a seed, a forward and a back pass over the visited vertices and adjacency
// entries, and a serial multiply then divide per predecessor term in the shared unit
// after reset a sweep empties the lists and zeroes the scores; no word
// is taken meanwhile
// one word at a time; the next word is taken once the result sits in the output register
`default_nettype none

module betweenness_centrality_engine_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bce_in_if.sink     i_in,
    bce_out_if.source  o_out,
    bce_cfg_if.sink    i_cfg
);
    import bce_pkg::*;

    `include "betweenness_centrality_engine_core_assert.svh"

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_INIT_V, S_SEED,
        S_BFS_POP, S_BFS_U, S_BFS_U2, S_BFS_EDGE, S_BFS_T, S_BFS_W,
        S_REV_POP, S_REV_W, S_REV_W2, S_REV_EDGE, S_REV_T, S_REV_P, S_REV_DIV,
        S_REV_CENT, S_REV_CENT2, S_NEXT_SRC,
        S_ADD_A, S_ADD_A2, S_ADD_B, S_ADD_B2, S_READ, S_READ2, S_DONE
    } t_state;

    typedef enum logic [1:0] {SW_RESET, SW_CLEAR, SW_RUN} t_sweep;

    t_state             r_state;
    t_sweep             r_sweep;
    logic [VCNT_W-1:0]  r_vcount;
    logic [EPTR_W-1:0]  r_entry_cnt;
    logic               r_sat;
    logic [VCNT_W-1:0]  r_idx;
    logic [VADDR_W-1:0] r_a;
    logic [VADDR_W-1:0] r_b;
    logic [VADDR_W-1:0] r_s;
    logic [VCNT_W-1:0]  r_qh;
    logic [VCNT_W-1:0]  r_qt;
    logic [VADDR_W-1:0] r_w;
    logic [VADDR_W-1:0] r_p;
    logic [EPTR_W-1:0]  r_e;
    logic [DIST_W-1:0]  r_du;
    logic [PATH_W-1:0]  r_pu;
    logic [DIST_W-1:0]  r_dw;
    logic [PATH_W-1:0]  r_pw;
    logic [SCORE_W-1:0] r_depw;
    logic [SCORE_W-1:0] r_depp;
    t_status            r_res_status;
    logic [SCORE_W-1:0] r_res_score;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_sat;

    // memory ports
    logic               hd_we, tg_we, nx_we, ds_we, pc_we, dp_we, ce_we, vo_we;
    logic [VADDR_W-1:0] hd_waddr, hd_raddr, ds_waddr, ds_raddr, pc_waddr, pc_raddr;
    logic [VADDR_W-1:0] dp_waddr, dp_raddr, ce_waddr, ce_raddr, vo_waddr, vo_raddr;
    logic [EADDR_W-1:0] tg_waddr, tg_raddr, nx_waddr, nx_raddr;
    logic [EPTR_W-1:0]  hd_wdata, hd_rdata, nx_wdata, nx_rdata;
    logic [VADDR_W-1:0] tg_wdata, tg_rdata, vo_wdata, vo_rdata;
    logic [DIST_W-1:0]  ds_wdata, ds_rdata;
    logic [PATH_W-1:0]  pc_wdata, pc_rdata;
    logic [SCORE_W-1:0] dp_wdata, dp_rdata, ce_wdata, ce_rdata;

    logic               md_start;
    logic               md_done;
    logic [SCORE_W-1:0] md_q;

    logic [VCNT_W-1:0]  n_nv;
    logic [EADDR_W-1:0] n_slot0;
    logic [EADDR_W-1:0] n_slot1;
    logic               n_claim;
    logic [DIST_W-1:0]  n_du1;
    logic               n_path_upd;
    logic [PATH_W:0]    n_path_sum;
    logic               n_term;
    logic [DIST_W:0]    n_dp1;
    logic [SCORE_W:0]   n_dep_sum;
    logic [SCORE_W:0]   n_cent_sum;

    bce_ram #(.WIDTH(EPTR_W), .DEPTH(MAX_VERTICES)) u_head (
        .i_clk, .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_rdata));
    bce_ram #(.WIDTH(VADDR_W), .DEPTH(MAX_EDGE_ENTRIES)) u_target (
        .i_clk, .i_we(tg_we), .i_waddr(tg_waddr), .i_wdata(tg_wdata),
        .i_raddr(tg_raddr), .o_rdata(tg_rdata));
    bce_ram #(.WIDTH(EPTR_W), .DEPTH(MAX_EDGE_ENTRIES)) u_next (
        .i_clk, .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata));
    bce_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist (
        .i_clk, .i_we(ds_we), .i_waddr(ds_waddr), .i_wdata(ds_wdata),
        .i_raddr(ds_raddr), .o_rdata(ds_rdata));
    bce_ram #(.WIDTH(PATH_W), .DEPTH(MAX_VERTICES)) u_paths (
        .i_clk, .i_we(pc_we), .i_waddr(pc_waddr), .i_wdata(pc_wdata),
        .i_raddr(pc_raddr), .o_rdata(pc_rdata));
    bce_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_dep (
        .i_clk, .i_we(dp_we), .i_waddr(dp_waddr), .i_wdata(dp_wdata),
        .i_raddr(dp_raddr), .o_rdata(dp_rdata));
    bce_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_cent (
        .i_clk, .i_we(ce_we), .i_waddr(ce_waddr), .i_wdata(ce_wdata),
        .i_raddr(ce_raddr), .o_rdata(ce_rdata));
    bce_ram #(.WIDTH(VADDR_W), .DEPTH(MAX_VERTICES)) u_order (
        .i_clk, .i_we(vo_we), .i_waddr(vo_waddr), .i_wdata(vo_wdata),
        .i_raddr(vo_raddr), .o_rdata(vo_rdata));

    bce_muldiv u_muldiv (
        .i_clk, .i_rst_n,
        .i_start(md_start),
        .i_a(pc_rdata),
        .i_b({1'b0, r_depw} + ONE_FIXED),
        .i_d(r_pw),
        .o_done(md_done),
        .o_q(md_q)
    );

    // datapath decisions
    always_comb begin
        n_nv       = (r_vcount > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vcount;
        n_slot0    = r_entry_cnt[EADDR_W-1:0];
        n_slot1    = r_entry_cnt[EADDR_W-1:0] + 1'b1;
        n_du1      = r_du + 1'b1;
        n_claim    = (ds_rdata == UNREACHED) && (r_qt < n_nv);
        n_path_upd = n_claim || (ds_rdata == n_du1);
        n_path_sum = {1'b0, pc_rdata} + {1'b0, r_pu};
        n_dp1      = {1'b0, ds_rdata} + 1'b1;
        n_term     = (ds_rdata != UNREACHED) && (n_dp1 == {1'b0, r_dw}) && (r_pw != '0);
        n_dep_sum  = {1'b0, r_depp} + {1'b0, md_q};
        n_cent_sum = {1'b0, ce_rdata} + {1'b0, r_depw};
    end

    // memory port control
    always_comb begin
        hd_we = 1'b0; hd_waddr = r_a; hd_wdata = LIST_END; hd_raddr = r_a;
        tg_we = 1'b0; tg_waddr = n_slot0; tg_wdata = r_b; tg_raddr = r_e[EADDR_W-1:0];
        nx_we = 1'b0; nx_waddr = n_slot0; nx_wdata = hd_rdata; nx_raddr = r_e[EADDR_W-1:0];
        ds_we = 1'b0; ds_waddr = r_idx[VADDR_W-1:0]; ds_wdata = UNREACHED; ds_raddr = tg_rdata;
        pc_we = 1'b0; pc_waddr = r_idx[VADDR_W-1:0]; pc_wdata = '0; pc_raddr = tg_rdata;
        dp_we = 1'b0; dp_waddr = r_idx[VADDR_W-1:0]; dp_wdata = '0; dp_raddr = tg_rdata;
        ce_we = 1'b0; ce_waddr = r_idx[VADDR_W-1:0]; ce_wdata = '0; ce_raddr = r_w;
        vo_we = 1'b0; vo_waddr = r_qt[VADDR_W-1:0]; vo_wdata = r_w;
        vo_raddr = r_qh[VADDR_W-1:0];
        md_start = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                hd_we    = (r_sweep != SW_RUN);
                hd_waddr = r_idx[VADDR_W-1:0];
                ce_we    = (r_sweep != SW_CLEAR);
            end
            S_INIT_V: begin
                ds_we = 1'b1;
                pc_we = 1'b1;
                dp_we = 1'b1;
            end
            S_SEED: begin
                ds_we    = 1'b1; ds_waddr = r_s; ds_wdata = '0;
                pc_we    = 1'b1; pc_waddr = r_s; pc_wdata = PATH_W'(1);
                vo_we    = 1'b1; vo_waddr = '0;  vo_wdata = r_s;
            end
            S_BFS_U, S_REV_W: begin
                hd_raddr = vo_rdata;
                ds_raddr = vo_rdata;
                pc_raddr = vo_rdata;
                dp_raddr = vo_rdata;
            end
            S_BFS_W: begin
                ds_we    = n_claim; ds_waddr = r_w; ds_wdata = n_du1;
                vo_we    = n_claim;
                pc_we    = n_path_upd; pc_waddr = r_w;
                pc_wdata = n_path_sum[PATH_W] ? PATH_MAX : n_path_sum[PATH_W-1:0];
            end
            S_REV_POP: vo_raddr = VADDR_W'(r_qt - 1'b1);
            S_REV_P:   md_start = n_term;
            S_REV_DIV: begin
                dp_we    = md_done; dp_waddr = r_p;
                dp_wdata = n_dep_sum[SCORE_W] ? SCORE_MAX : n_dep_sum[SCORE_W-1:0];
            end
            S_REV_CENT2: begin
                ce_we    = 1'b1; ce_waddr = r_w;
                ce_wdata = n_cent_sum[SCORE_W] ? SCORE_MAX : n_cent_sum[SCORE_W-1:0];
            end
            S_ADD_A2: begin
                nx_we = 1'b1;
                tg_we = 1'b1;
                hd_we = 1'b1; hd_wdata = r_entry_cnt;
            end
            S_ADD_B: hd_raddr = r_b;
            S_ADD_B2: begin
                nx_we = 1'b1; nx_waddr = n_slot1;
                tg_we = 1'b1; tg_waddr = n_slot1; tg_wdata = r_a;
                hd_we = 1'b1; hd_waddr = r_b; hd_wdata = {1'b0, n_slot1};
            end
            S_READ: ce_raddr = r_a;
            default: ;
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= SW_RESET;
            r_idx       <= '0;
            r_vcount    <= '0;
            r_entry_cnt <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_vcount <= i_cfg.vertex_count;
            end
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    if (r_idx == VCNT_W'(MAX_VERTICES - 1)) begin
                        r_idx <= '0;
                        r_s   <= '0;
                        unique case (r_sweep)
                            SW_RESET: r_state <= S_IDLE;
                            SW_CLEAR: r_state <= S_DONE;
                            SW_RUN:   r_state <= (n_nv == '0) ? S_DONE : S_INIT_V;
                            default:  r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_a          <= i_in.vertex_a;
                        r_b          <= i_in.vertex_b;
                        r_res_score  <= '0;
                        r_idx        <= '0;
                        unique case (t_op'(i_in.op))
                            OP_ADD: begin
                                if (({1'b0, i_in.vertex_a} >= n_nv) ||
                                    ({1'b0, i_in.vertex_b} >= n_nv)) begin
                                    r_res_status <= ST_ENDPOINT;
                                    r_state      <= S_DONE;
                                end else if ({1'b0, r_entry_cnt} + 2'd2 >
                                             {1'b0, LIST_END}) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_ADD_A;
                                end
                            end
                            OP_RUN: begin
                                r_res_status <= ST_OK;
                                r_sat        <= 1'b0;
                                r_sweep      <= SW_RUN;
                                r_state      <= S_SWEEP;
                            end
                            OP_READ: begin
                                if ({1'b0, i_in.vertex_a} >= n_nv) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_READ;
                                end
                            end
                            OP_CLEAR: begin
                                r_res_status <= ST_OK;
                                r_entry_cnt  <= '0;
                                r_sweep      <= SW_CLEAR;
                                r_state      <= S_SWEEP;
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INIT_V: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == n_nv) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_qh    <= '0;
                    r_qt    <= VCNT_W'(1);
                    r_state <= S_BFS_POP;
                end
                // breadth-first pass
                S_BFS_POP: begin
                    if (r_qh == r_qt) begin
                        r_state <= S_REV_POP;
                    end else begin
                        r_qh    <= r_qh + 1'b1;
                        r_state <= S_BFS_U;
                    end
                end
                S_BFS_U: r_state <= S_BFS_U2;
                S_BFS_U2: begin
                    r_du    <= ds_rdata;
                    r_pu    <= pc_rdata;
                    r_e     <= hd_rdata;
                    r_state <= S_BFS_EDGE;
                end
                S_BFS_EDGE: r_state <= (r_e < r_entry_cnt) ? S_BFS_T : S_BFS_POP;
                S_BFS_T: begin
                    r_w     <= tg_rdata;
                    r_e     <= nx_rdata;
                    r_state <= ({1'b0, tg_rdata} < n_nv) ? S_BFS_W : S_BFS_EDGE;
                end
                S_BFS_W: begin
                    if (n_claim) begin
                        r_qt <= r_qt + 1'b1;
                    end
                    if (n_path_upd && n_path_sum[PATH_W]) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= S_BFS_EDGE;
                end
                // reverse dependency pass
                S_REV_POP: begin
                    if (r_qt == '0) begin
                        r_state <= S_NEXT_SRC;
                    end else begin
                        r_qt    <= r_qt - 1'b1;
                        r_state <= S_REV_W;
                    end
                end
                S_REV_W: begin
                    r_w     <= vo_rdata;
                    r_state <= S_REV_W2;
                end
                S_REV_W2: begin
                    r_dw    <= ds_rdata;
                    r_pw    <= pc_rdata;
                    r_depw  <= dp_rdata;
                    r_e     <= hd_rdata;
                    r_state <= S_REV_EDGE;
                end
                S_REV_EDGE: begin
                    if (r_e < r_entry_cnt) begin
                        r_state <= S_REV_T;
                    end else begin
                        r_state <= (r_w != r_s) ? S_REV_CENT : S_REV_POP;
                    end
                end
                S_REV_T: begin
                    r_p     <= tg_rdata;
                    r_e     <= nx_rdata;
                    r_state <= ({1'b0, tg_rdata} < n_nv) ? S_REV_P : S_REV_EDGE;
                end
                S_REV_P: begin
                    r_depp  <= dp_rdata;
                    r_state <= n_term ? S_REV_DIV : S_REV_EDGE;
                end
                S_REV_DIV: begin
                    if (md_done) begin
                        r_state <= S_REV_EDGE;
                    end
                end
                S_REV_CENT:  r_state <= S_REV_CENT2;
                S_REV_CENT2: r_state <= S_REV_POP;
                S_NEXT_SRC: begin
                    r_idx <= '0;
                    if ({1'b0, r_s} + 1'b1 == n_nv) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_INIT_V;
                    end
                end
                // edge load, both directions
                S_ADD_A:  r_state <= S_ADD_A2;
                S_ADD_A2: r_state <= S_ADD_B;
                S_ADD_B:  r_state <= S_ADD_B2;
                S_ADD_B2: begin
                    r_entry_cnt <= r_entry_cnt + 2'd2;
                    r_state     <= S_DONE;
                end
                S_READ:  r_state <= S_READ2;
                S_READ2: begin
                    r_res_score <= ce_rdata;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_score  <= r_res_score;
                        r_out_sat    <= r_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.score     = r_out_score;
    assign o_out.saturated = r_out_sat;

    `BCE_ASSERT_ALWAYS(a_entry_even, i_clk, i_rst_n, !r_entry_cnt[0] && (r_entry_cnt <= LIST_END), "entry count odd or past store size")
    `BCE_ASSERT_IMPLY(a_queue_order, i_clk, i_rst_n, r_state == S_BFS_POP, (r_qh <= r_qt) && (r_qt <= n_nv), "visit queue pointers out of order")
    `BCE_ASSERT_IMPLY(a_div_done, i_clk, i_rst_n, md_done, r_state == S_REV_DIV, "divider finished while no term awaited")
    `BCE_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input taken twice in a row")
endmodule

`default_nettype wire
